// File: src/cln_pkg.sv
// Package: types, codes and nibble tables for the character LCD nibble sequencer.
`default_nettype none
package cln_pkg;

    typedef enum logic [2:0] {
        MODE_INIT   = 3'd0,
        MODE_CMD    = 3'd1,
        MODE_DATA   = 3'd2,
        MODE_CURSOR = 3'd3,
        MODE_CLEAR  = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        CFG_ENABLE_PHASE = 2'd0,
        CFG_INIT_WAIT    = 2'd1,
        CFG_SETUP_WAIT   = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        WSEL_NONE,
        WSEL_INIT,
        WSEL_SETUP
    } t_wsel;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_state;

    localparam int unsigned CFG_W     = 8;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned INIT_LEN  = 14;
    localparam int unsigned STEP_W    = $clog2(INIT_LEN);

    localparam logic [CFG_W-1:0] INIT_WAIT_RST  = 8'd5;
    localparam logic [CFG_W-1:0] SETUP_WAIT_RST = 8'd2;

    localparam logic [7:0] CURSOR_CMD   = 8'h80;
    localparam logic [7:0] ROW1_BASE    = 8'h40;
    localparam logic [7:0] CLEAR_BYTE   = 8'h01;
    localparam logic [7:0] HOME_BYTE    = 8'h02;
    localparam logic [1:0] ROW_WITH_BASE = 2'd1;

    // wake-up 3,3,3,2 then 0x28 0x0F 0x06 0x01 0x02, high nibble first
    localparam logic [3:0] INIT_NIB [INIT_LEN] = '{
        4'h3, 4'h3, 4'h3, 4'h2,
        4'h2, 4'h8, 4'h0, 4'hF,
        4'h0, 4'h6, 4'h0, 4'h1,
        4'h0, 4'h2
    };

    localparam t_wsel INIT_WSEL [INIT_LEN] = '{
        WSEL_INIT, WSEL_INIT, WSEL_INIT, WSEL_NONE,
        WSEL_NONE, WSEL_SETUP, WSEL_NONE, WSEL_SETUP,
        WSEL_NONE, WSEL_NONE, WSEL_NONE, WSEL_NONE,
        WSEL_NONE, WSEL_NONE
    };

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] byte_value;
        logic [1:0] row;
        logic [5:0] column;
        logic       chip_sel;
    } t_req;

    typedef struct packed {
        logic [3:0] data_nibble;
        logic       reg_select;
        logic       enable_line;
        logic [7:0] wait_after_ms;
        logic       last_transfer;
    } t_xfer;

    typedef struct packed {
        logic take_req;
        logic capture;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic req_valid;
        logic mode_ok;
        logic slot_free;
        logic last_step;
    } t_stat;

    function automatic logic [STEP_W-1:0] last_step_of(input logic [2:0] mode);
        logic [STEP_W-1:0] res;
        case (mode)
            MODE_INIT:  res = STEP_W'(INIT_LEN - 1);
            MODE_CLEAR: res = STEP_W'(3);
            default:    res = STEP_W'(1);
        endcase
        return res;
    endfunction

endpackage
`default_nettype wire

// File: src/cln_stream_if.sv
// Interface: valid/ready channel carrying one request payload.
`default_nettype none
interface cln_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: src/cln_ctrl.sv
// Controller: idle/emit state machine issuing capture and load commands.
`default_nettype none
module cln_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire cln_pkg::t_stat i_stat,
    output cln_pkg::t_cmd      o_cmd
);
    import cln_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.take_req = 1'b1;
                if (i_stat.req_valid) begin
                    o_cmd.capture = 1'b1;
                    if (i_stat.mode_ok) begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (i_stat.slot_free) begin
                    o_cmd.load = 1'b1;
                    if (i_stat.last_step) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: src/cln_dpath.sv
// Datapath: request and config registers, step counter, nibble select, output register.
`default_nettype none
module cln_dpath (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    cln_stream_if.sink                      i_req,
    cln_stream_if.source                    o_xfer,
    input  wire logic                       i_cfg_we,
    input  wire logic [cln_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [cln_pkg::CFG_W-1:0]  i_cfg_data,
    input  wire cln_pkg::t_cmd              i_cmd,
    output cln_pkg::t_stat                  o_stat
);
    import cln_pkg::*;

    t_req              r_req;
    logic [STEP_W-1:0] r_step;
    logic [CFG_W-1:0]  r_init_wait;
    logic [CFG_W-1:0]  r_setup_wait;
    t_xfer             r_out;
    logic              r_out_valid;

    t_xfer             n_xfer;
    logic [7:0]        cur_byte;
    t_mode             in_mode;

    assign in_mode = t_mode'(i_req.payload.mode);

    // enable phase length is written but nothing is stored here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_wait  <= INIT_WAIT_RST;
            r_setup_wait <= SETUP_WAIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ENABLE_PHASE: ;
                CFG_INIT_WAIT:    r_init_wait  <= i_cfg_data;
                CFG_SETUP_WAIT:   r_setup_wait <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_req.payload;
        end
        if (i_cmd.load) begin
            r_out <= n_xfer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.capture) begin
                r_step <= '0;
            end else if (i_cmd.load) begin
                r_step <= r_step + STEP_W'(1);
            end
            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (o_xfer.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        cur_byte = '0;
        case (r_req.mode)
            MODE_CMD, MODE_DATA: cur_byte = r_req.byte_value;
            MODE_CURSOR: cur_byte = CURSOR_CMD
                                  | ((r_req.row == ROW_WITH_BASE) ? ROW1_BASE : 8'h00)
                                  | {2'b00, r_req.column};
            MODE_CLEAR:  cur_byte = r_step[1] ? HOME_BYTE : CLEAR_BYTE;
            default:     cur_byte = '0;
        endcase
    end

    always_comb begin
        n_xfer               = '0;
        n_xfer.enable_line   = r_req.chip_sel;
        n_xfer.reg_select    = (r_req.mode == MODE_DATA);
        n_xfer.last_transfer = (r_step == last_step_of(r_req.mode));
        n_xfer.data_nibble   = r_step[0] ? cur_byte[3:0] : cur_byte[7:4];
        if (r_req.mode == MODE_INIT) begin
            n_xfer.data_nibble = INIT_NIB[r_step];
            case (INIT_WSEL[r_step])
                WSEL_INIT:  n_xfer.wait_after_ms = r_init_wait;
                WSEL_SETUP: n_xfer.wait_after_ms = r_setup_wait;
                default:    n_xfer.wait_after_ms = '0;
            endcase
        end
    end

    assign i_req.ready     = i_cmd.take_req;
    assign o_xfer.valid    = r_out_valid;
    assign o_xfer.payload  = r_out;

    assign o_stat.req_valid = i_req.valid;
    assign o_stat.mode_ok   = in_mode inside {[MODE_INIT:MODE_CLEAR]};
    assign o_stat.slot_free = !r_out_valid || o_xfer.ready;
    assign o_stat.last_step = n_xfer.last_transfer;

endmodule
`default_nettype wire

// File: src/char_lcd_nibble_sequencer_unit.sv
// Top level: character LCD 4-bit nibble sequencer.
// Takes one request at a time and emits its nibble transfers from a step counter, one
// per cycle unless the output is stalled: init gives 14 transfers, clear 4, write
// command, write data and set cursor 2. A request with an undefined mode is taken and
// gives nothing. The next request is taken while the final transfer still waits in
// the output register. Configuration writes must be made only while the block is
// idle; the block itself does not enforce this.
`default_nettype none
module char_lcd_nibble_sequencer_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    cln_stream_if.sink                         i_req,
    cln_stream_if.source                       o_xfer,
    input  wire logic                          i_cfg_we,
    input  wire logic [cln_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [cln_pkg::CFG_W-1:0]     i_cfg_data
);
    import cln_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    cln_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    cln_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .o_xfer     (o_xfer),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_stat     (stat)
    );

    a_bad_mode_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready && !stat.mode_ok) |=> !$rose(o_xfer.valid))
        else $error("undefined mode produced a transfer");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready && stat.mode_ok) |=> !i_req.ready)
        else $error("request taken while a sequence is starting");

    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.load && stat.last_step) |=> i_req.ready)
        else $error("not ready after final transfer");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |=> o_xfer.valid)
        else $error("loaded transfer not presented");

endmodule
`default_nettype wire

// File: sim/testbench.sv
// Testbench: directed table and random requests for the LCD nibble sequencer, checked per transfer.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import cln_pkg::*;

    localparam int unsigned ITEMS_PER_PHASE = 70;
    localparam int unsigned N_PHASES        = 4;
    localparam int unsigned HOLD_AT         = 200;
    localparam int unsigned HOLD_LEN        = 96;
    localparam int unsigned SETTLE_CYCLES   = 4;
    localparam int unsigned TAIL_CYCLES     = 16;
    localparam int unsigned WATCHDOG_LIMIT  = 2000;

    localparam logic [3:0] WAKE_NIB   = 4'h3;
    localparam logic [3:0] BUS4_NIB   = 4'h2;
    localparam logic [7:0] FUNC_SET   = 8'h28;
    localparam logic [7:0] DISP_ON    = 8'h0F;
    localparam logic [7:0] ENTRY_MODE = 8'h06;

    typedef struct {
        t_req  req;
        bit    typed;
        t_xfer hi;
        t_xfer lo;
    } t_dir_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    cln_stream_if #(.T(t_req))  req_if ();
    cln_stream_if #(.T(t_xfer)) xfer_if ();

    char_lcd_nibble_sequencer_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .o_xfer     (xfer_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    t_xfer       expected_xfers[$];
    t_dir_row    dir_rows[$];
    logic [7:0]  phase_ms_cfg;
    logic [7:0]  init_wait_cfg;
    logic [7:0]  setup_wait_cfg;
    bit          no_idle;
    int unsigned error_count;
    int unsigned xfers_seen;
    int unsigned rx_gap;
    int unsigned rx_hold;
    int unsigned idle_cycles;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic t_req rq(logic [2:0] mode, logic [7:0] b, logic [1:0] row,
                                logic [5:0] col, logic chip);
        t_req r;
        r.mode       = mode;
        r.byte_value = b;
        r.row        = row;
        r.column     = col;
        r.chip_sel   = chip;
        return r;
    endfunction

    function automatic t_xfer xf(logic [3:0] nib, logic rs, logic en, logic [7:0] w,
                                 logic last);
        t_xfer x;
        x.data_nibble   = nib;
        x.reg_select    = rs;
        x.enable_line   = en;
        x.wait_after_ms = w;
        x.last_transfer = last;
        return x;
    endfunction

    task automatic push_byte(logic [7:0] b, logic rs, logic en, logic [7:0] w, logic last);
        expected_xfers.push_back(xf(b[7:4], rs, en, 8'd0, 1'b0));
        expected_xfers.push_back(xf(b[3:0], rs, en, w, last));
    endtask

    task automatic predict_transfers(t_req r);
        logic [7:0] addr;
        addr = CURSOR_CMD | ((r.row == ROW_WITH_BASE) ? ROW1_BASE : 8'h00) | {2'b00, r.column};
        case (r.mode)
            MODE_INIT: begin
                repeat (3) expected_xfers.push_back(xf(WAKE_NIB, 1'b0, r.chip_sel,
                                                       init_wait_cfg, 1'b0));
                expected_xfers.push_back(xf(BUS4_NIB, 1'b0, r.chip_sel, 8'd0, 1'b0));
                push_byte(FUNC_SET, 1'b0, r.chip_sel, setup_wait_cfg, 1'b0);
                push_byte(DISP_ON, 1'b0, r.chip_sel, setup_wait_cfg, 1'b0);
                push_byte(ENTRY_MODE, 1'b0, r.chip_sel, 8'd0, 1'b0);
                push_byte(CLEAR_BYTE, 1'b0, r.chip_sel, 8'd0, 1'b0);
                push_byte(HOME_BYTE, 1'b0, r.chip_sel, 8'd0, 1'b1);
            end
            MODE_CMD:    push_byte(r.byte_value, 1'b0, r.chip_sel, 8'd0, 1'b1);
            MODE_DATA:   push_byte(r.byte_value, 1'b1, r.chip_sel, 8'd0, 1'b1);
            MODE_CURSOR: push_byte(addr, 1'b0, r.chip_sel, 8'd0, 1'b1);
            MODE_CLEAR: begin
                push_byte(CLEAR_BYTE, 1'b0, r.chip_sel, 8'd0, 1'b0);
                push_byte(HOME_BYTE, 1'b0, r.chip_sel, 8'd0, 1'b1);
            end
            default: ;
        endcase
    endtask

    function automatic t_req random_request();
        int unsigned pick;
        logic [2:0]  mode;
        pick = $urandom_range(0, 99);
        if (pick < 12)      mode = MODE_INIT;
        else if (pick < 32) mode = MODE_CMD;
        else if (pick < 54) mode = MODE_DATA;
        else if (pick < 76) mode = MODE_CURSOR;
        else if (pick < 90) mode = MODE_CLEAR;
        else                mode = 3'($urandom_range(5, 7));
        return rq(mode, 8'($urandom), 2'($urandom), 6'($urandom), 1'($urandom));
    endfunction

    task automatic send_request(t_req r);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.payload <= r;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    // drop valid, let every expected transfer drain, then give in-flight requests time
    task automatic settle();
        req_if.valid <= 1'b0;
        while (expected_xfers.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [7:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        case (idx)
            CFG_ENABLE_PHASE: phase_ms_cfg   = v;
            CFG_INIT_WAIT:    init_wait_cfg  = v;
            CFG_SETUP_WAIT:   setup_wait_cfg = v;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic configure(logic [7:0] phase_ms, logic [7:0] init_w, logic [7:0] setup_w);
        write_reg(CFG_ENABLE_PHASE, phase_ms);
        write_reg(CFG_INIT_WAIT, init_w);
        write_reg(CFG_SETUP_WAIT, setup_w);
        i_cfg_we <= 1'b0;
    endtask

    // result side: check, count, and pace ready
    always @(posedge i_clk) begin
        t_xfer want;
        t_xfer got;
        if (!i_rst_n) begin
            xfer_if.ready <= 1'b0;
            rx_gap  = 0;
            rx_hold = 0;
        end else begin
            if (xfer_if.valid && xfer_if.ready) begin
                got = xfer_if.payload;
                if (expected_xfers.size() == 0) begin
                    $error("unexpected transfer %h", got);
                    error_count++;
                end else begin
                    want = expected_xfers.pop_front();
                    if (got.data_nibble !== want.data_nibble) begin
                        $error("data_nibble: expected %0h, got %0h",
                               want.data_nibble, got.data_nibble);
                        error_count++;
                    end
                    if (got.reg_select !== want.reg_select) begin
                        $error("reg_select: expected %0b, got %0b",
                               want.reg_select, got.reg_select);
                        error_count++;
                    end
                    if (got.enable_line !== want.enable_line) begin
                        $error("enable_line: expected %0b, got %0b",
                               want.enable_line, got.enable_line);
                        error_count++;
                    end
                    if (got.wait_after_ms !== want.wait_after_ms) begin
                        $error("wait_after_ms: expected %0d, got %0d",
                               want.wait_after_ms, got.wait_after_ms);
                        error_count++;
                    end
                    if (got.last_transfer !== want.last_transfer) begin
                        $error("last_transfer: expected %0b, got %0b",
                               want.last_transfer, got.last_transfer);
                        error_count++;
                    end
                end
                xfers_seen++;
                if (xfers_seen == HOLD_AT) rx_hold = HOLD_LEN;
                rx_gap = no_idle ? 0 : $urandom_range(0, 3);
            end
            if (rx_hold > 0) begin
                rx_hold--;
                xfer_if.ready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                xfer_if.ready <= 1'b0;
            end else begin
                xfer_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles = 0;
        end else if ((req_if.valid && req_if.ready) || (xfer_if.valid && xfer_if.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        t_req        r;
        int unsigned n_valid;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = '0;
        i_cfg_data     = '0;
        req_if.valid   = 1'b0;
        req_if.payload = '0;
        xfer_if.ready  = 1'b0;
        no_idle        = 1'b0;
        error_count    = 0;
        xfers_seen     = 0;
        phase_ms_cfg   = 8'd1;
        init_wait_cfg  = 8'd5;
        setup_wait_cfg = 8'd2;

        dir_rows.push_back('{rq(MODE_INIT, 8'h00, 2'd0, 6'd0, 1'b0), 1'b0, '0, '0});
        dir_rows.push_back('{rq(MODE_CMD, 8'h00, 2'd0, 6'd0, 1'b0), 1'b1,
                             xf(4'h0, 1'b0, 1'b0, 8'd0, 1'b0), xf(4'h0, 1'b0, 1'b0, 8'd0, 1'b1)});
        dir_rows.push_back('{rq(MODE_CMD, 8'hFF, 2'd3, 6'd63, 1'b1), 1'b1,
                             xf(4'hF, 1'b0, 1'b1, 8'd0, 1'b0), xf(4'hF, 1'b0, 1'b1, 8'd0, 1'b1)});
        dir_rows.push_back('{rq(MODE_DATA, 8'h00, 2'd0, 6'd0, 1'b1), 1'b1,
                             xf(4'h0, 1'b1, 1'b1, 8'd0, 1'b0), xf(4'h0, 1'b1, 1'b1, 8'd0, 1'b1)});
        dir_rows.push_back('{rq(MODE_DATA, 8'hFF, 2'd3, 6'd63, 1'b0), 1'b1,
                             xf(4'hF, 1'b1, 1'b0, 8'd0, 1'b0), xf(4'hF, 1'b1, 1'b0, 8'd0, 1'b1)});
        dir_rows.push_back('{rq(MODE_DATA, 8'hA5, 2'd1, 6'd21, 1'b0), 1'b0, '0, '0});
        dir_rows.push_back('{rq(MODE_CURSOR, 8'hFF, 2'd0, 6'd0, 1'b0), 1'b1,
                             xf(4'h8, 1'b0, 1'b0, 8'd0, 1'b0), xf(4'h0, 1'b0, 1'b0, 8'd0, 1'b1)});
        dir_rows.push_back('{rq(MODE_CURSOR, 8'h00, 2'd1, 6'd0, 1'b1), 1'b1,
                             xf(4'hC, 1'b0, 1'b1, 8'd0, 1'b0), xf(4'h0, 1'b0, 1'b1, 8'd0, 1'b1)});
        dir_rows.push_back('{rq(MODE_CURSOR, 8'h00, 2'd2, 6'd63, 1'b0), 1'b1,
                             xf(4'hB, 1'b0, 1'b0, 8'd0, 1'b0), xf(4'hF, 1'b0, 1'b0, 8'd0, 1'b1)});
        dir_rows.push_back('{rq(MODE_CURSOR, 8'h00, 2'd1, 6'd63, 1'b1), 1'b1,
                             xf(4'hF, 1'b0, 1'b1, 8'd0, 1'b0), xf(4'hF, 1'b0, 1'b1, 8'd0, 1'b1)});
        dir_rows.push_back('{rq(MODE_CURSOR, 8'h5A, 2'd3, 6'd5, 1'b0), 1'b0, '0, '0});
        dir_rows.push_back('{rq(MODE_CURSOR, 8'h00, 2'd1, 6'd42, 1'b0), 1'b0, '0, '0});
        dir_rows.push_back('{rq(MODE_CLEAR, 8'h00, 2'd0, 6'd0, 1'b0), 1'b0, '0, '0});
        dir_rows.push_back('{rq(MODE_CLEAR, 8'hFF, 2'd3, 6'd63, 1'b1), 1'b0, '0, '0});
        dir_rows.push_back('{rq(MODE_INIT, 8'hFF, 2'd3, 6'd63, 1'b1), 1'b0, '0, '0});
        // undefined modes give nothing
        dir_rows.push_back('{rq(3'd5, 8'h00, 2'd0, 6'd0, 1'b0), 1'b1, '0, '0});
        dir_rows.push_back('{rq(3'd6, 8'h3C, 2'd1, 6'd7, 1'b1), 1'b1, '0, '0});
        dir_rows.push_back('{rq(3'd7, 8'hFF, 2'd3, 6'd63, 1'b1), 1'b1, '0, '0});
        dir_rows.push_back('{rq(MODE_CMD, 8'h5A, 2'd2, 6'd9, 1'b1), 1'b0, '0, '0});
        dir_rows.push_back('{rq(MODE_DATA, 8'h3C, 2'd0, 6'd33, 1'b0), 1'b0, '0, '0});

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            send_request(dir_rows[i].req);
            if (!dir_rows[i].typed) begin
                predict_transfers(dir_rows[i].req);
            end else if (dir_rows[i].req.mode inside {MODE_CMD, MODE_DATA, MODE_CURSOR}) begin
                expected_xfers.push_back(dir_rows[i].hi);
                expected_xfers.push_back(dir_rows[i].lo);
            end
        end

        for (int phase = 0; phase < N_PHASES; phase++) begin
            settle();
            case (phase)
                0:       configure(8'd1, 8'd0, 8'd0);
                1:       configure(8'd255, 8'd255, 8'd255);
                default: configure(8'($urandom_range(1, 255)), 8'($urandom), 8'($urandom));
            endcase
            no_idle = (phase == 1);
            n_valid = 0;
            while (n_valid < ITEMS_PER_PHASE) begin
                r = random_request();
                send_request(r);
                predict_transfers(r);
                if (r.mode <= MODE_CLEAR) n_valid++;
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
